// ===== src/segment_label_stream_engine_top_defines.svh =====
// Assertion macros for the segment label stream engine.
`ifndef SEGMENT_LABEL_STREAM_ENGINE_TOP_DEFINES_SVH
`define SEGMENT_LABEL_STREAM_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLSE_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLSE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slse_pkg.sv =====
// Package: widths, tag codes and transaction types of the segment label stream engine.
`default_nettype none

package slse_pkg;

  localparam int ID_BITS    = 8;
  localparam int COUNT_BITS = 16;
  localparam int EPOCH_BITS = 8;

  typedef enum logic [1:0] {
    TAG_O = 2'd0,
    TAG_B = 2'd1,
    TAG_I = 2'd2
  } iob_tag_t;

  typedef struct packed {
    logic [ID_BITS-1:0] seg_id;
    logic               seq_last;
  } tok_t;

  typedef struct packed {
    iob_tag_t              iob_tag;
    logic [ID_BITS-1:0]    new_id;
    logic [ID_BITS-1:0]    distinct_count;
    logic [ID_BITS-1:0]    disjoint_count;
    logic [COUNT_BITS-1:0] unannotated_count;
    logic                  out_last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/segment_label_stream_engine_top.sv =====
// Segment label stream engine: IOB tagging, id renumbering and segment counts.
//
// Usage:
//   tok channel (tok_valid/tok_ready/tok) carries one token per transaction:
//   segment id and a flag marking the last token of a sequence.
//   res channel (res_valid/res_ready/res) returns one transaction per token:
//   IOB tag, renumbered id, distinct/disjoint/unannotated counts, last flag.
//   An accepted token is held in the table stage, then its result is registered
//   in the res output register. Throughput: one token per cycle while res_ready
//   is high and no clearing pass runs, set by a single read-modify-write of the
//   per-id table memory per token; a write-to-read forward covers back-to-back
//   tokens with the same id. Table entries carry a sequence epoch, so a sequence
//   end needs no clearing. A clearing pass over all 2^ID_BITS entries (tok_ready
//   low) runs after reset and after every 2^EPOCH_BITS-1 sequences as the epoch
//   wraps, and tok_ready drops while the wrapping last token is in the table stage.
//   rst (synchronous) empties the pipeline, clears all counts and starts the
//   clearing pass.
//   When res_ready is low, one token waits in the table stage and one result in
//   the output register; tok_ready drops until the result is taken.
`default_nettype none

`include "segment_label_stream_engine_top_defines.svh"

module segment_label_stream_engine_top #(
  parameter int EPOCH_BITS = slse_pkg::EPOCH_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          tok_valid,
  output logic               tok_ready,
  input  wire slse_pkg::tok_t tok,
  output logic               res_valid,
  input  wire logic          res_ready,
  output slse_pkg::res_t     res
);

  localparam int IDB   = slse_pkg::ID_BITS;
  localparam int CNTB  = slse_pkg::COUNT_BITS;
  localparam int DEPTH = 1 << IDB;
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic                  disj;
    logic [IDB-1:0]        remap;
  } entry_t;

  entry_t mem [DEPTH];

  // control
  logic                  sweeping;
  logic [IDB-1:0]        sweep_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic                  s1_valid;
  slse_pkg::tok_t        s1;
  entry_t                rd_word;
  logic                  fwd_valid;
  logic [IDB-1:0]        fwd_addr;
  entry_t                fwd_data;

  // sequence state
  logic [IDB-1:0]  begin_id;
  logic [IDB-1:0]  previous_id;
  logic [IDB-1:0]  next_new_id;
  logic [IDB-1:0]  disjoint_total;
  logic [CNTB-1:0] unannotated_total;

  logic                s1_adv;
  logic                tok_acc;
  logic                wrap_hold;
  entry_t              word;
  logic                seen;
  slse_pkg::iob_tag_t  tag;
  logic [IDB-1:0]      renum;
  logic [IDB-1:0]      begin_id_next;
  logic [IDB-1:0]      next_new_id_next;
  logic [IDB-1:0]      disjoint_total_next;
  logic [CNTB-1:0]     unannotated_total_next;
  entry_t              wr_word;
  logic                wr_en;
  logic [IDB-1:0]      wr_addr;
  entry_t              wr_data;

  assign s1_adv    = s1_valid && (!res_valid || res_ready);
  assign wrap_hold = s1_valid && s1.seq_last && (epoch == EPOCH_MAX);
  assign tok_ready = !sweeping && !wrap_hold && (!s1_valid || s1_adv);
  assign tok_acc   = tok_valid && tok_ready;

  always_comb begin
    word = (fwd_valid && (fwd_addr == s1.seg_id)) ? fwd_data : rd_word;
    seen = (word.epoch == epoch);
    tag = slse_pkg::TAG_O;
    renum = '0;
    begin_id_next = begin_id;
    next_new_id_next = next_new_id;
    disjoint_total_next = disjoint_total;
    unannotated_total_next = unannotated_total;
    wr_word.epoch = epoch;
    wr_word.disj = seen ? word.disj : 1'b0;
    wr_word.remap = word.remap;
    if (s1.seg_id == '0) begin
      if (unannotated_total != {CNTB{1'b1}}) begin
        unannotated_total_next = unannotated_total + CNTB'(1);
      end
    end else begin
      if (s1.seg_id == begin_id) begin
        tag = slse_pkg::TAG_I;
      end else begin
        tag = slse_pkg::TAG_B;
        begin_id_next = s1.seg_id;
      end
      if (seen) begin
        renum = word.remap;
        if ((previous_id != s1.seg_id) && !word.disj) begin
          wr_word.disj = 1'b1;
          disjoint_total_next = disjoint_total + IDB'(1);
        end
      end else begin
        next_new_id_next = next_new_id + IDB'(1);
        renum = next_new_id_next;
        wr_word.remap = next_new_id_next;
      end
    end
  end

  always_comb begin
    if (sweeping) begin
      wr_en = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else begin
      wr_en = s1_adv && (s1.seg_id != '0);
      wr_addr = s1.seg_id;
      wr_data = wr_word;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_acc) begin
      rd_word <= mem[tok.seg_id];
    end
  end

  always_ff @(posedge clk) begin
    if (tok_acc) begin
      s1 <= tok;
    end
    if (wr_en && !sweeping) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
    if (s1_adv) begin
      res.iob_tag <= tag;
      res.new_id <= renum;
      res.distinct_count <= next_new_id_next;
      res.disjoint_count <= disjoint_total_next;
      res.unannotated_count <= unannotated_total_next;
      res.out_last <= s1.seq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b1;
      sweep_addr <= '0;
      epoch <= EPOCH_FIRST;
      s1_valid <= 1'b0;
      res_valid <= 1'b0;
      fwd_valid <= 1'b0;
      begin_id <= '0;
      previous_id <= '0;
      next_new_id <= '0;
      disjoint_total <= '0;
      unannotated_total <= '0;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + IDB'(1);
        fwd_valid <= 1'b0;
        if (sweep_addr == {IDB{1'b1}}) begin
          sweeping <= 1'b0;
          epoch <= EPOCH_FIRST;
        end
      end else if (wr_en) begin
        fwd_valid <= 1'b1;
      end

      if (tok_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (s1_adv) begin
        if (s1.seq_last) begin
          begin_id <= '0;
          previous_id <= '0;
          next_new_id <= '0;
          disjoint_total <= '0;
          unannotated_total <= '0;
          if (epoch == EPOCH_MAX) begin
            sweeping <= 1'b1;
            sweep_addr <= '0;
          end else begin
            epoch <= epoch + EPOCH_BITS'(1);
          end
        end else begin
          begin_id <= begin_id_next;
          previous_id <= s1.seg_id;
          next_new_id <= next_new_id_next;
          disjoint_total <= disjoint_total_next;
          unannotated_total <= unannotated_total_next;
        end
      end
    end
  end

  `SLSE_ASSERT_NEXT(a_wrap_sweeps, clk, rst, s1_adv && s1.seq_last && (epoch == EPOCH_MAX), sweeping, "epoch wrap did not start a clearing pass")
  `SLSE_ASSERT_NOW(a_sweep_idle, clk, rst, sweeping, !s1_valid && !tok_acc, "token in flight during clearing pass")
  `SLSE_ASSERT_NOW(a_renum_range, clk, rst, res_valid && (res.iob_tag != slse_pkg::TAG_O), (res.new_id != '0) && (res.new_id <= res.distinct_count), "renumbered id out of range")

endmodule

`default_nettype wire
